// ===== rtl/mep_pkg.sv =====
// mep_pkg: widths, register codes, palette and helpers for the escape-time block
// no dependencies; used by every file in rtl
`timescale 1ns / 1ps

package mep_pkg;

    localparam int IDX_W      = 10;
    localparam int MAX_SIDE   = 1024;
    localparam int COORD_W    = 32;
    localparam int ITER_W     = 16;
    localparam int RGB_W      = 24;
    localparam int FRAC_BITS  = 28;
    localparam int RADIUS_LOG2 = 1;

    // magnitude bound of a z part while the point is still inside the radius
    localparam int MAG_BITS   = FRAC_BITS + RADIUS_LOG2;
    localparam int SQ_W       = 2 * MAG_BITS;
    localparam int Z_W        = COORD_W + 1;
    localparam int MUL_W      = Z_W;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int MAP_W      = IDX_W + COORD_W + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

    localparam logic signed [COORD_W-1:0] X_ORIGIN_RST = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] Y_ORIGIN_RST = -32'sd402653184;
    localparam logic signed [COORD_W-1:0] X_STEP_RST   = 32'sd1258291;
    localparam logic signed [COORD_W-1:0] Y_STEP_RST   = 32'sd1677722;
    localparam logic [ITER_W-1:0]         MAX_ITER_RST = 16'd1000;

    localparam logic [RGB_W-1:0] RGB_BLACK = '0;

    typedef logic [RGB_W-1:0] rgb_t;

    localparam rgb_t PALETTE [16] = '{
        24'h0F1E42, 24'h1A0719, 24'h2F0109, 24'h490404,
        24'h640700, 24'h8A2C0C, 24'hB15218, 24'hD17D39,
        24'hE5B586, 24'hF8ECD3, 24'hBFE9F1, 24'h5FC9F8,
        24'h00AAFF, 24'h0080CC, 24'h005799, 24'h03346A
    };

    // clamp a mapped coordinate to the signed coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [MAP_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if ((&v[MAP_W-1:COORD_W-1]) || !(|v[MAP_W-1:COORD_W-1]))
        begin
            r = v[COORD_W-1:0];
        end
        else if (v[MAP_W-1])
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== rtl/mep_in_if.sv =====
// mep_in_if: pixel request channel (column and row)
// depends on mep_pkg for field widths
`timescale 1ns / 1ps

interface mep_in_if;
    logic                      valid;
    logic                      ready;
    logic [mep_pkg::IDX_W-1:0] column;
    logic [mep_pkg::IDX_W-1:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink (input valid, input column, input row, output ready);
endinterface

// ===== rtl/mep_out_if.sv =====
// mep_out_if: pixel result channel (color and iteration count)
// depends on mep_pkg for field widths
`timescale 1ns / 1ps

interface mep_out_if;
    logic                       valid;
    logic                       ready;
    logic [mep_pkg::RGB_W-1:0]  pixel_rgb;
    logic [mep_pkg::ITER_W-1:0] iterations;

    modport source (output valid, output pixel_rgb, output iterations, input ready);
    modport sink (input valid, input pixel_rgb, input iterations, output ready);
endinterface

// ===== rtl/mep_mul.sv =====
// mep_mul: shared signed multiplier with a registered product
// depends on mep_pkg for operand and product widths
`timescale 1ns / 1ps

module mep_mul
(
    input  logic                               clk,
    input  logic signed [mep_pkg::MUL_W-1:0]   op_a,
    input  logic signed [mep_pkg::MUL_W-1:0]   op_b,
    output logic signed [mep_pkg::PROD_W-1:0]  prod
);

    logic signed [mep_pkg::PROD_W-1:0] prod_reg;
    logic signed [mep_pkg::PROD_W-1:0] prod_next;

    assign prod_next = mep_pkg::PROD_W'(op_a) * mep_pkg::PROD_W'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/mandelbrot_escape_pixel_color.sv =====
// Escape-time pixel colorer. Each pixel transaction maps column and row to c in signed Q4.28
// (origin + index * step, saturated), iterates z = z*z + c from zero and returns one result
// transaction: the iteration count and a color from a 16-entry palette, or black when the
// iteration limit (1000 after reset) is reached. One 33x33 multiplier is shared by the whole
// computation: the pixel is taken, the map x, map y and map c setup states form c, then each
// iteration runs a*a, b*b, a*b and update, with a last escape check either at a*a (a part
// already out of range) or at update, and the result is loaded when the output register is
// free, so a full result register holds the block back. The block takes one pixel at a time;
// the next pixel is accepted as soon as the previous result sits in the output register.
// Configuration registers are written through cfg_we / cfg_index / cfg_data and must only
// change while the block is idle.
// depends on mep_pkg, mep_in_if, mep_out_if, mep_mul
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_color
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mep_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]      cfg_data,
    mep_in_if.sink                              pixel,
    mep_out_if.source                           result
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MAP_X  = 4'd1;
    localparam logic [3:0] S_MAP_Y  = 4'd2;
    localparam logic [3:0] S_MAP_C  = 4'd3;
    localparam logic [3:0] S_SQ_A   = 4'd4;
    localparam logic [3:0] S_SQ_B   = 4'd5;
    localparam logic [3:0] S_MUL_AB = 4'd6;
    localparam logic [3:0] S_UPDATE = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    localparam logic signed [mep_pkg::Z_W-1:0] MAG_LIM =
        mep_pkg::Z_W'(64'd1 << mep_pkg::MAG_BITS);

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic signed [mep_pkg::COORD_W-1:0] x_origin_reg;
    logic signed [mep_pkg::COORD_W-1:0] y_origin_reg;
    logic signed [mep_pkg::COORD_W-1:0] x_step_reg;
    logic signed [mep_pkg::COORD_W-1:0] y_step_reg;
    logic [mep_pkg::ITER_W-1:0]         max_iter_reg;

    logic [mep_pkg::IDX_W-1:0]          col_reg;
    logic [mep_pkg::IDX_W-1:0]          row_reg;
    logic signed [mep_pkg::COORD_W-1:0] cx_reg;
    logic signed [mep_pkg::COORD_W-1:0] cy_reg;
    logic signed [mep_pkg::Z_W-1:0]     a_reg;
    logic signed [mep_pkg::Z_W-1:0]     b_reg;
    logic [mep_pkg::SQ_W-1:0]           a2_reg;
    logic [mep_pkg::SQ_W-1:0]           b2_reg;
    logic [mep_pkg::ITER_W-1:0]         n_reg;

    logic                               out_valid_reg;
    mep_pkg::rgb_t                      rgb_reg;
    logic [mep_pkg::ITER_W-1:0]         iter_reg;

    logic signed [mep_pkg::MUL_W-1:0]   op_a;
    logic signed [mep_pkg::MUL_W-1:0]   op_b;
    logic signed [mep_pkg::PROD_W-1:0]  prod;

    logic [mep_pkg::IDX_W-1:0]          col_clamped;
    logic [mep_pkg::IDX_W-1:0]          row_clamped;
    logic signed [mep_pkg::MAP_W-1:0]   map_prod;
    logic signed [mep_pkg::MAP_W-1:0]   map_x_sum;
    logic signed [mep_pkg::MAP_W-1:0]   map_y_sum;
    logic [mep_pkg::SQ_W:0]             mag_sum;
    logic signed [mep_pkg::SQ_W:0]      sq_diff;
    logic signed [mep_pkg::Z_W-1:0]     re_next;
    logic signed [mep_pkg::Z_W-1:0]     im_next;
    logic                               in_range;
    logic                               escaped;
    logic                               limit_hit;
    logic                               out_free;
    logic                               accept;

    // index beyond the side is pinned to the last column or row
    assign col_clamped = (32'(pixel.column) >= 32'(mep_pkg::MAX_SIDE)) ?
                         mep_pkg::IDX_W'(mep_pkg::MAX_SIDE - 1) : pixel.column;
    assign row_clamped = (32'(pixel.row) >= 32'(mep_pkg::MAX_SIDE)) ?
                         mep_pkg::IDX_W'(mep_pkg::MAX_SIDE - 1) : pixel.row;

    assign accept   = pixel.valid && pixel.ready;
    assign out_free = !out_valid_reg || result.ready;

    assign map_prod  = $signed(prod[mep_pkg::MAP_W-1:0]);
    assign map_x_sum = map_prod + mep_pkg::MAP_W'(x_origin_reg);
    assign map_y_sum = map_prod + mep_pkg::MAP_W'(y_origin_reg);

    assign in_range = (a_reg < MAG_LIM) && (a_reg > -MAG_LIM) &&
                      (b_reg < MAG_LIM) && (b_reg > -MAG_LIM);

    assign mag_sum   = {1'b0, a2_reg} + {1'b0, b2_reg};
    assign escaped   = mag_sum[mep_pkg::SQ_W];
    assign limit_hit = (n_reg >= max_iter_reg);
    assign sq_diff   = $signed({1'b0, a2_reg}) - $signed({1'b0, b2_reg});
    assign re_next   = mep_pkg::Z_W'($signed(sq_diff[mep_pkg::SQ_W:mep_pkg::FRAC_BITS]))
                     + mep_pkg::Z_W'(cx_reg);
    assign im_next   = mep_pkg::Z_W'($signed(prod[mep_pkg::SQ_W-1:mep_pkg::FRAC_BITS-1]))
                     + mep_pkg::Z_W'(cy_reg);

    always_comb
    begin
        unique case (state_reg)
            S_MAP_X:
            begin
                op_a = mep_pkg::MUL_W'($signed({1'b0, col_reg}));
                op_b = mep_pkg::MUL_W'(x_step_reg);
            end
            S_MAP_Y:
            begin
                op_a = mep_pkg::MUL_W'($signed({1'b0, row_reg}));
                op_b = mep_pkg::MUL_W'(y_step_reg);
            end
            S_SQ_A:
            begin
                op_a = a_reg;
                op_b = a_reg;
            end
            S_SQ_B:
            begin
                op_a = b_reg;
                op_b = b_reg;
            end
            default:
            begin
                op_a = a_reg;
                op_b = b_reg;
            end
        endcase
    end

    mep_mul u_mul
    (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pixel.valid)
                begin
                    state_next = S_MAP_X;
                end
            end
            S_MAP_X:  state_next = S_MAP_Y;
            S_MAP_Y:  state_next = S_MAP_C;
            S_MAP_C:  state_next = S_SQ_A;
            S_SQ_A:   state_next = in_range ? S_SQ_B : S_DONE;
            S_SQ_B:   state_next = S_MUL_AB;
            S_MUL_AB: state_next = S_UPDATE;
            S_UPDATE: state_next = (escaped || limit_hit) ? S_DONE : S_SQ_A;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= mep_pkg::X_ORIGIN_RST;
            y_origin_reg <= mep_pkg::Y_ORIGIN_RST;
            x_step_reg   <= mep_pkg::X_STEP_RST;
            y_step_reg   <= mep_pkg::Y_STEP_RST;
            max_iter_reg <= mep_pkg::MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mep_pkg::REG_X_ORIGIN: x_origin_reg <= $signed(cfg_data[mep_pkg::COORD_W-1:0]);
                mep_pkg::REG_Y_ORIGIN: y_origin_reg <= $signed(cfg_data[mep_pkg::COORD_W-1:0]);
                mep_pkg::REG_X_STEP:   x_step_reg   <= $signed(cfg_data[mep_pkg::COORD_W-1:0]);
                mep_pkg::REG_Y_STEP:   y_step_reg   <= $signed(cfg_data[mep_pkg::COORD_W-1:0]);
                mep_pkg::REG_MAX_ITER: max_iter_reg <= cfg_data[mep_pkg::ITER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg <= col_clamped;
            row_reg <= row_clamped;
            a_reg   <= '0;
            b_reg   <= '0;
            n_reg   <= '0;
        end
        if (state_reg == S_MAP_Y)
        begin
            cx_reg <= mep_pkg::sat_coord(map_x_sum);
        end
        if (state_reg == S_MAP_C)
        begin
            cy_reg <= mep_pkg::sat_coord(map_y_sum);
        end
        if (state_reg == S_SQ_B)
        begin
            a2_reg <= prod[mep_pkg::SQ_W-1:0];
        end
        if (state_reg == S_MUL_AB)
        begin
            b2_reg <= prod[mep_pkg::SQ_W-1:0];
        end
        if (state_reg == S_UPDATE && !escaped && !limit_hit)
        begin
            a_reg <= re_next;
            b_reg <= im_next;
            n_reg <= n_reg + 1'b1;
        end
        if (state_reg == S_DONE && out_free)
        begin
            rgb_reg  <= limit_hit ? mep_pkg::RGB_BLACK : mep_pkg::PALETTE[n_reg[3:0]];
            iter_reg <= n_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign pixel.ready       = (state_reg == S_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.pixel_rgb  = rgb_reg;
    assign result.iterations = iter_reg;

endmodule

// ===== rtl/mep_checker.sv =====
// mep_checker: port-level assertions for the escape-time block, bound to the top level
// depends on mep_pkg for the palette and field widths
`timescale 1ns / 1ps

module mep_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pix_valid,
    input  logic                       pix_ready,
    input  logic                       res_valid,
    input  logic                       res_ready,
    input  logic [mep_pkg::RGB_W-1:0]  pixel_rgb,
    input  logic [mep_pkg::ITER_W-1:0] iterations
);

    // one pixel at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready) |=> !pix_ready)
        else $error("pixel accepted while a pixel is in flight");

    // a result appears only from the busy phase
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(pix_ready))
        else $error("result appeared without a pixel in progress");

    // color is black or the palette entry for the iteration count
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (pixel_rgb == mep_pkg::RGB_BLACK) ||
                      (pixel_rgb == mep_pkg::PALETTE[iterations[3:0]]))
        else $error("pixel color does not match the iteration count");

    // stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid && $stable(pixel_rgb) && $stable(iterations))
        else $error("stalled result changed");

endmodule

bind mandelbrot_escape_pixel_color mep_checker u_mep_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pixel.valid),
    .pix_ready  (pixel.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .pixel_rgb  (result.pixel_rgb),
    .iterations (result.iterations)
);

// ===== verif/tb_mandelbrot_escape_pixel_color.sv =====
// tb_mandelbrot_escape_pixel_color: self-checking bench for the escape-time pixel colorer
// directed table then random views, results checked against a typed value or fixed-point model
// depends on mep_pkg, mep_in_if, mep_out_if and mandelbrot_escape_pixel_color
`timescale 1ns / 1ps

module tb_mandelbrot_escape_pixel_color;

    import mep_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int Q_ONE = 1 << FRAC_BITS;
    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;
    localparam logic [127:0] ESCAPE_LIMIT = 128'd4 << (2 * FRAC_BITS);

    typedef struct packed {
        rgb_t              rgb;
        logic [ITER_W-1:0] iters;
    } pixel_res_t;

    typedef struct {
        bit                load_view;
        logic [31:0]       xo;
        logic [31:0]       yo;
        logic [31:0]       xs;
        logic [31:0]       ys;
        logic [ITER_W-1:0] mi;
        bit                junk;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
        bit                typed;
        pixel_res_t        res;
    } dir_case_t;

    typedef enum {RX_STREAM, RX_COIN, RX_MOSTLY_ON, RX_MOSTLY_OFF} rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mep_in_if  pix_if ();
    mep_out_if res_if ();

    mandelbrot_escape_pixel_color dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pix_if),
        .result    (res_if)
    );

    // model copy of the view registers
    logic signed [COORD_W-1:0] view_x_origin = X_ORIGIN_RST;
    logic signed [COORD_W-1:0] view_y_origin = Y_ORIGIN_RST;
    logic signed [COORD_W-1:0] view_x_step   = X_STEP_RST;
    logic signed [COORD_W-1:0] view_y_step   = Y_STEP_RST;
    logic [ITER_W-1:0]         iter_limit    = MAX_ITER_RST;

    pixel_res_t expected_pixels [$];
    dir_case_t  dir_cases [$];
    int         mismatch_count = 0;
    int         burst_left = 0;
    bit         typed_pending = 1'b0;
    pixel_res_t typed_result;
    bit         rx_hold_pending = 1'b0;
    int         rx_hold_left = 0;
    int         rx_seg_left = 0;
    rx_mode_t   rx_mode = RX_STREAM;
    pixel_res_t got_pixel;
    pixel_res_t want_pixel;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic signed [COORD_W-1:0] map_axis(input logic signed [COORD_W-1:0] origin,
                                                           input logic signed [COORD_W-1:0] step,
                                                           input logic [IDX_W-1:0] idx);
        logic signed [63:0] o64;
        logic signed [63:0] s64;
        logic signed [63:0] i64;
        logic signed [63:0] v;
        o64 = origin;
        s64 = step;
        i64 = {54'd0, idx};
        v = o64 + i64 * s64;
        if (v > 64'sd2147483647)
        begin
            return S32_MAX;
        end
        if (v < -64'sd2147483648)
        begin
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] sat_wide(input logic signed [127:0] x);
        if ((&x[127:63]) || !(|x[127:63]))
        begin
            return x[63:0];
        end
        return x[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    endfunction

    function automatic pixel_res_t escape_color(input logic [IDX_W-1:0] col,
                                                input logic [IDX_W-1:0] row);
        logic signed [127:0] cx_w;
        logic signed [127:0] cy_w;
        logic signed [127:0] za;
        logic signed [127:0] zb;
        logic signed [127:0] a_sq;
        logic signed [127:0] b_sq;
        logic signed [127:0] re;
        logic signed [127:0] im;
        logic [127:0]        mag;
        logic signed [63:0]  a;
        logic signed [63:0]  b;
        int unsigned         n;
        pixel_res_t          r;
        cx_w = map_axis(view_x_origin, view_x_step, col);
        cy_w = map_axis(view_y_origin, view_y_step, row);
        a = '0;
        b = '0;
        a_sq = '0;
        b_sq = '0;
        mag = '0;
        n = 0;
        while (mag < ESCAPE_LIMIT && n < iter_limit)
        begin
            za = a;
            zb = b;
            re = (a_sq - b_sq) >>> FRAC_BITS;
            im = (za * zb) >>> (FRAC_BITS - 1);
            a = sat_wide(re + cx_w);
            b = sat_wide(im + cy_w);
            n++;
            za = a;
            zb = b;
            a_sq = za * za;
            b_sq = zb * zb;
            mag = a_sq + b_sq;
        end
        r.rgb = (n < iter_limit) ? PALETTE[n[3:0]] : RGB_BLACK;
        r.iters = n[ITER_W-1:0];
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic add_case(input bit load_view, input logic [31:0] xo, input logic [31:0] yo,
                            input logic [31:0] xs, input logic [31:0] ys,
                            input logic [ITER_W-1:0] mi, input bit junk,
                            input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row,
                            input bit typed, input pixel_res_t res);
        dir_case_t c;
        c.load_view = load_view;
        c.xo = xo;
        c.yo = yo;
        c.xs = xs;
        c.ys = ys;
        c.mi = mi;
        c.junk = junk;
        c.col = col;
        c.row = row;
        c.typed = typed;
        c.res = res;
        dir_cases.push_back(c);
    endtask

    // all five registers, plus writes to the unused indexes when junk is set
    task automatic write_view(input logic [31:0] xo, input logic [31:0] yo,
                              input logic [31:0] xs, input logic [31:0] ys,
                              input logic [ITER_W-1:0] mi, input bit junk);
        logic [31:0] data;
        int          k;
        for (k = 0; k < 8; k++)
        begin
            if (k <= REG_MAX_ITER || junk)
            begin
                case (3'(k))
                    REG_X_ORIGIN:
                    begin
                        data = xo;
                        view_x_origin = xo;
                    end
                    REG_Y_ORIGIN:
                    begin
                        data = yo;
                        view_y_origin = yo;
                    end
                    REG_X_STEP:
                    begin
                        data = xs;
                        view_x_step = xs;
                    end
                    REG_Y_STEP:
                    begin
                        data = ys;
                        view_y_step = ys;
                    end
                    REG_MAX_ITER:
                    begin
                        data = {16'd0, mi};
                        iter_limit = mi;
                    end
                    default:
                    begin
                        data = $urandom;
                    end
                endcase
                cfg_we <= 1'b1;
                cfg_index <= 3'(k);
                cfg_data <= data;
                @(negedge clk);
            end
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        @(negedge clk);
        while (expected_pixels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic drive_pixel(input logic [IDX_W-1:0] px_col, input logic [IDX_W-1:0] px_row);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            if (gap != 0)
            begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        pix_if.valid <= 1'b1;
        pix_if.column <= px_col;
        pix_if.row <= px_row;
        @(posedge clk);
        while (!pix_if.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_pending)
            begin
                rx_hold_pending = 1'b0;
                rx_hold_left = 1200;
            end
            if (rx_seg_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_seg_left = $urandom_range(16, 300);
            end
            rx_seg_left--;
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_STREAM:     res_if.ready <= 1'b1;
                    RX_COIN:       res_if.ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY_ON:  res_if.ready <= ($urandom_range(0, 7) != 0);
                    default:       res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                got_pixel.rgb = res_if.pixel_rgb;
                got_pixel.iters = res_if.iterations;
                if (expected_pixels.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected result rgb %06h iterations %0d",
                                           got_pixel.rgb, got_pixel.iters));
                end
                else
                begin
                    want_pixel = expected_pixels.pop_front();
                    if (got_pixel.rgb !== want_pixel.rgb)
                    begin
                        log_mismatch($sformatf("pixel_rgb expected %06h got %06h",
                                               want_pixel.rgb, got_pixel.rgb));
                    end
                    if (got_pixel.iters !== want_pixel.iters)
                    begin
                        log_mismatch($sformatf("iterations expected %0d got %0d",
                                               want_pixel.iters, got_pixel.iters));
                    end
                end
            end
            if (pix_if.valid && pix_if.ready)
            begin
                if (typed_pending)
                begin
                    expected_pixels.push_back(typed_result);
                end
                else
                begin
                    expected_pixels.push_back(escape_color(pix_if.column, pix_if.row));
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int        k;
        int        ph;
        int        it;
        int        kind;
        int        n_items;
        int        xo;
        int        yo;
        int        xs;
        int        ys;
        int        mi;
        dir_case_t dc;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.column = '0;
        pix_if.row = '0;

        // reset view first, then fixed points and register extremes
        add_case(0, 0, 0, 0, 0, 0, 0, 10'd0, 10'd0, 1, {PALETTE[1], 16'd1});
        add_case(0, 0, 0, 0, 0, 0, 0, 10'd1023, 10'd1023, 0, '0);
        add_case(0, 0, 0, 0, 0, 0, 0, 10'd320, 10'd240, 0, '0);
        add_case(1, 0, 0, 0, 0, 16'd0, 0, 10'd5, 10'd7, 1, {RGB_BLACK, 16'd0});
        add_case(1, 0, 0, 0, 0, 16'd1, 0, 10'd1023, 10'd0, 1, {RGB_BLACK, 16'd1});
        add_case(1, 0, 0, 0, 0, 16'd1000, 0, 10'd0, 10'd1023, 1, {RGB_BLACK, 16'd1000});
        add_case(1, -2 * Q_ONE, 0, 0, 0, 16'd1000, 0, 10'd512, 10'd512, 1,
                 {PALETTE[1], 16'd1});
        add_case(1, -Q_ONE, 0, 0, 0, 16'd50, 0, 10'd33, 10'd99, 1, {RGB_BLACK, 16'd50});
        add_case(1, S32_MAX, S32_MAX, S32_MAX, S32_MAX, 16'hFFFF, 0, 10'd1023, 10'd1023, 1,
                 {PALETTE[1], 16'd1});
        add_case(1, S32_MIN, S32_MIN, S32_MIN, S32_MIN, 16'hFFFF, 0, 10'd1023, 10'd1023, 1,
                 {PALETTE[1], 16'd1});
        add_case(1, S32_MAX, S32_MIN, S32_MIN, S32_MAX, 16'd1000, 0, 10'd1023, 10'd0, 0, '0);
        add_case(1, S32_MAX, S32_MIN, S32_MIN, S32_MAX, 16'd1000, 0, 10'd0, 10'd1023, 0, '0);
        add_case(1, Q_ONE / 4, 0, 0, 0, 16'd200, 0, 10'd0, 10'd0, 0, '0);
        add_case(1, Q_ONE / 4 + Q_ONE / 100, 0, 0, 0, 16'd1000, 0, 10'd2, 10'd3, 0, '0);
        add_case(1, -2 * Q_ONE, 0, 1, 0, 16'd100, 0, 10'd1, 10'd0, 0, '0);
        add_case(1, 0, Q_ONE, 0, 0, 16'd100, 0, 10'd7, 10'd9, 0, '0);
        add_case(1, Q_ONE / 2, 0, 0, 0, 16'd1000, 0, 10'd682, 10'd341, 0, '0);
        add_case(1, 0, 0, 0, 0, 16'hFFFF, 0, 10'd1, 10'd1, 1, {RGB_BLACK, 16'hFFFF});
        add_case(1, X_ORIGIN_RST, Y_ORIGIN_RST, X_STEP_RST, Y_STEP_RST, MAX_ITER_RST, 1,
                 10'd100, 10'd100, 0, '0);
        add_case(1, -3 * Q_ONE / 4, Q_ONE / 10, 0, 0, 16'hFFFF, 0, 10'd0, 10'd0, 0, '0);
        add_case(1, -Q_ONE / 2, -Q_ONE / 2, 4096, -4096, 16'd16, 0, 10'd1023, 10'd1023, 0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < dir_cases.size(); k++)
        begin
            dc = dir_cases[k];
            if (dc.load_view)
            begin
                wait_drained();
                write_view(dc.xo, dc.yo, dc.xs, dc.ys, dc.mi, dc.junk);
            end
            typed_pending = dc.typed;
            typed_result = dc.res;
            drive_pixel(dc.col, dc.row);
            typed_pending = 1'b0;
        end

        for (ph = 0; ph < 12; ph++)
        begin
            kind = (ph == 7) ? 3 : ph % 3;
            case (kind)
                0, 3:
                begin
                    xo = -(5 * Q_ONE / 2) + $urandom_range(0, Q_ONE / 4);
                    yo = -(3 * Q_ONE / 2) + $urandom_range(0, Q_ONE / 4);
                    xs = $urandom_range(200000, 1000000);
                    ys = $urandom_range(200000, 1000000);
                    mi = (kind == 3) ? 1000 : $urandom_range(1, 64);
                end
                1:
                begin
                    xo = -2 * Q_ONE + $urandom_range(0, 5 * Q_ONE / 2);
                    yo = -Q_ONE + $urandom_range(0, 2 * Q_ONE);
                    xs = $urandom_range(0, 8191) - 4096;
                    ys = $urandom_range(0, 8191) - 4096;
                    mi = $urandom_range(16, 255);
                end
                default:
                begin
                    xo = $urandom;
                    yo = $urandom;
                    xs = $urandom;
                    ys = $urandom;
                    mi = $urandom_range(1, 300);
                end
            endcase
            wait_drained();
            write_view(xo, yo, xs, ys, 16'(mi), ph == 2);
            n_items = (kind == 3) ? 20 : 53;
            for (it = 0; it < n_items; it++)
            begin
                if (ph == 0 && it == 20)
                begin
                    rx_hold_pending = 1'b1;
                end
                if (ph == 4 && it == 25)
                begin
                    wait_drained();
                end
                drive_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
            end
        end

        wait_drained();
        repeat (64) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
